// ===== hw/rtl/swerve_drive_wheel_kinematics_assert.svh =====
// Assertion macros for the swerve drive wheel kinematics block.
// Used by the port checker; depends on nothing else.
`ifndef SWERVE_DRIVE_WHEEL_KINEMATICS_ASSERT_SVH
`define SWERVE_DRIVE_WHEEL_KINEMATICS_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define SDWK_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define SDWK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdwk_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the swerve kinematics block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package sdwk_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int NUM_WHEELS   = 4;
    localparam int WHEEL_W      = 2;
    localparam int CW           = 56;
    localparam int ZW           = 34;

    localparam logic signed [16:0] INV_GAIN     = 17'sd39797;
    localparam logic signed [17:0] DEG_PER_TURN = 18'sd92160;
    localparam logic signed [42:0] GATE_Q48     = 43'sd28147;
    localparam logic signed [17:0] SPD_MAX      = 18'sd131071;
    localparam logic signed [17:0] SPD_MIN      = -18'sd131072;
    localparam logic signed [17:0] DIR_ONE      = 18'sd4096;

    localparam logic [1:0] REG_ARM_X = 2'd0;
    localparam logic [1:0] REG_ARM_Y = 2'd1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_HOLD,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_VEC_STEP,
        OP_GX_LO,
        OP_GX_HI,
        OP_GY_LO,
        OP_GY_HI,
        OP_ARM,
        OP_WVEC,
        OP_DOT,
        OP_CROSS,
        OP_DIFF,
        OP_SQ,
        OP_GATE,
        OP_ANG_INIT,
        OP_ANG_LO,
        OP_ANG_HI,
        OP_SPD_INIT,
        OP_MAG_LO,
        OP_MAG_HI,
        OP_PUBLISH
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD_DEC,
        S_ROT,
        S_GX_LO,
        S_GX_HI,
        S_GY_LO,
        S_GY_HI,
        S_ARM,
        S_WVEC,
        S_DOT,
        S_CROSS,
        S_DIFF,
        S_SQ,
        S_GATE,
        S_DECIDE,
        S_ANG_STEP,
        S_ANG_LO,
        S_ANG_HI,
        S_SPD_INIT,
        S_SPD_STEP,
        S_MAG_LO,
        S_MAG_HI,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [STEP_W-1:0]  step;
        logic [WHEEL_W-1:0] wheel;
    } t_cmd;

    typedef struct packed {
        logic standby;
        logic zero_cmd;
        logic gate;
    } t_sts;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sh020000000;
            5'd1:    v = 34'sh012E4051D;
            5'd2:    v = 34'sh009FB385B;
            5'd3:    v = 34'sh0051111D4;
            5'd4:    v = 34'sh0028B0D43;
            5'd5:    v = 34'sh00145D7E1;
            5'd6:    v = 34'sh000A2F61E;
            5'd7:    v = 34'sh000517C55;
            5'd8:    v = 34'sh00028BE53;
            5'd9:    v = 34'sh000145F2E;
            5'd10:   v = 34'sh0000A2F98;
            5'd11:   v = 34'sh0000517CC;
            5'd12:   v = 34'sh000028BE6;
            5'd13:   v = 34'sh0000145F3;
            5'd14:   v = 34'sh000000A2F9;
            5'd15:   v = 34'sh00000517C;
            5'd16:   v = 34'sh0000028BE;
            5'd17:   v = 34'sh00000145F;
            5'd18:   v = 34'sh000000A2F;
            5'd19:   v = 34'sh000000517;
            5'd20:   v = 34'sh00000028B;
            5'd21:   v = 34'sh000000145;
            5'd22:   v = 34'sh0000000A2;
            5'd23:   v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swerve_drive_wheel_kinematics.sv =====
// One shared CORDIC unit, one step a cycle, runs one rotation pass per command and up to two
// vectoring passes per wheel; a wheel whose turn is too small skips its angle pass.
// Standby and all-zero commands skip the CORDIC passes. One command is processed at a time;
// the next is accepted while the finished result waits in the output register. Reset is
// synchronous, active low: wheel directions go to (1,0), angles, flips and levers to zero,
// no result valid.
`default_nettype none

module swerve_drive_wheel_kinematics (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_standby,
    input  wire signed [15:0]   i_vel_x,
    input  wire signed [15:0]   i_vel_y,
    input  wire signed [15:0]   i_omega,
    input  wire signed [15:0]   i_heading,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [31:0]  o_angle_front_right,
    output logic signed [31:0]  o_angle_rear_right,
    output logic signed [31:0]  o_angle_front_left,
    output logic signed [31:0]  o_angle_rear_left,
    output logic signed [17:0]  o_speed_front_right,
    output logic signed [17:0]  o_speed_rear_right,
    output logic signed [17:0]  o_speed_front_left,
    output logic signed [17:0]  o_speed_rear_left,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic signed [15:0]  r_arm_x, r_arm_y;
    logic [1:0]          reg_idx;
    sdwk_pkg::t_cmd      cmd;
    sdwk_pkg::t_sts      sts;
    logic signed [31:0]  angle [sdwk_pkg::NUM_WHEELS];
    logic signed [17:0]  speed [sdwk_pkg::NUM_WHEELS];

    assign reg_idx = {1'b0, paddr[2]};
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_x <= '0;
            r_arm_y <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                sdwk_pkg::REG_ARM_X: r_arm_x <= pwdata[15:0];
                sdwk_pkg::REG_ARM_Y: r_arm_y <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sdwk_pkg::REG_ARM_X: prdata = 32'(r_arm_x);
            sdwk_pkg::REG_ARM_Y: prdata = 32'(r_arm_y);
            default:             prdata = '0;
        endcase
    end

    sdwk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sdwk_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_standby (i_standby),
        .i_vel_x   (i_vel_x),
        .i_vel_y   (i_vel_y),
        .i_omega   (i_omega),
        .i_heading (i_heading),
        .i_arm_x   (r_arm_x),
        .i_arm_y   (r_arm_y),
        .o_angle   (angle),
        .o_speed   (speed)
    );

    assign o_angle_front_right = angle[0];
    assign o_angle_rear_right  = angle[1];
    assign o_angle_front_left  = angle[2];
    assign o_angle_rear_left   = angle[3];
    assign o_speed_front_right = speed[0];
    assign o_speed_rear_right  = speed[1];
    assign o_speed_front_left  = speed[2];
    assign o_speed_rear_left   = speed[3];

endmodule

`default_nettype wire

// ===== hw/rtl/sdwk_ctrl.sv =====
// Sequencing state machine for the swerve kinematics block.
// Depends on sdwk_pkg; drives commands into sdwk_dp and owns both handshakes.
`default_nettype none

module sdwk_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_ready,
    input  sdwk_pkg::t_sts      i_sts,
    output sdwk_pkg::t_cmd      o_cmd
);

    sdwk_pkg::t_state                 r_state, n_state;
    logic [sdwk_pkg::STEP_W-1:0]      r_step, n_step;
    logic [sdwk_pkg::WHEEL_W-1:0]     r_wheel, n_wheel;
    logic                             r_out_valid, n_out_valid;
    logic                             step_last;

    assign step_last = (r_step == sdwk_pkg::STEP_W'(sdwk_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdwk_pkg::S_IDLE;
            r_step      <= '0;
            r_wheel     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_wheel     <= n_wheel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_wheel     = r_wheel;
        n_out_valid = r_out_valid;
        o_cmd.op    = sdwk_pkg::OP_NONE;
        o_cmd.step  = r_step;
        o_cmd.wheel = r_wheel;
        o_ready     = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            sdwk_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = sdwk_pkg::OP_LOAD;
                    n_state  = sdwk_pkg::S_LOAD_DEC;
                end
            end
            sdwk_pkg::S_LOAD_DEC: begin
                n_step  = '0;
                n_wheel = '0;
                if (i_sts.standby) begin
                    o_cmd.op = sdwk_pkg::OP_CLEAR;
                    n_state  = sdwk_pkg::S_DONE;
                end else if (i_sts.zero_cmd) begin
                    o_cmd.op = sdwk_pkg::OP_HOLD;
                    n_state  = sdwk_pkg::S_DONE;
                end else begin
                    o_cmd.op = sdwk_pkg::OP_ROT_INIT;
                    n_state  = sdwk_pkg::S_ROT;
                end
            end
            sdwk_pkg::S_ROT: begin
                o_cmd.op = sdwk_pkg::OP_ROT_STEP;
                n_step   = r_step + 1'b1;
                if (step_last) begin
                    n_step  = '0;
                    n_state = sdwk_pkg::S_GX_LO;
                end
            end
            sdwk_pkg::S_GX_LO: begin
                o_cmd.op = sdwk_pkg::OP_GX_LO;
                n_state  = sdwk_pkg::S_GX_HI;
            end
            sdwk_pkg::S_GX_HI: begin
                o_cmd.op = sdwk_pkg::OP_GX_HI;
                n_state  = sdwk_pkg::S_GY_LO;
            end
            sdwk_pkg::S_GY_LO: begin
                o_cmd.op = sdwk_pkg::OP_GY_LO;
                n_state  = sdwk_pkg::S_GY_HI;
            end
            sdwk_pkg::S_GY_HI: begin
                o_cmd.op = sdwk_pkg::OP_GY_HI;
                n_state  = sdwk_pkg::S_ARM;
            end
            sdwk_pkg::S_ARM: begin
                o_cmd.op = sdwk_pkg::OP_ARM;
                n_state  = sdwk_pkg::S_WVEC;
            end
            sdwk_pkg::S_WVEC: begin
                o_cmd.op = sdwk_pkg::OP_WVEC;
                n_state  = sdwk_pkg::S_DOT;
            end
            sdwk_pkg::S_DOT: begin
                o_cmd.op = sdwk_pkg::OP_DOT;
                n_state  = sdwk_pkg::S_CROSS;
            end
            sdwk_pkg::S_CROSS: begin
                o_cmd.op = sdwk_pkg::OP_CROSS;
                n_state  = sdwk_pkg::S_DIFF;
            end
            sdwk_pkg::S_DIFF: begin
                o_cmd.op = sdwk_pkg::OP_DIFF;
                n_state  = sdwk_pkg::S_SQ;
            end
            sdwk_pkg::S_SQ: begin
                o_cmd.op = sdwk_pkg::OP_SQ;
                n_state  = sdwk_pkg::S_GATE;
            end
            sdwk_pkg::S_GATE: begin
                o_cmd.op = sdwk_pkg::OP_GATE;
                n_state  = sdwk_pkg::S_DECIDE;
            end
            sdwk_pkg::S_DECIDE: begin
                n_step = '0;
                if (i_sts.gate) begin
                    o_cmd.op = sdwk_pkg::OP_ANG_INIT;
                    n_state  = sdwk_pkg::S_ANG_STEP;
                end else begin
                    o_cmd.op = sdwk_pkg::OP_SPD_INIT;
                    n_state  = sdwk_pkg::S_SPD_STEP;
                end
            end
            sdwk_pkg::S_ANG_STEP: begin
                o_cmd.op = sdwk_pkg::OP_VEC_STEP;
                n_step   = r_step + 1'b1;
                if (step_last) begin
                    n_step  = '0;
                    n_state = sdwk_pkg::S_ANG_LO;
                end
            end
            sdwk_pkg::S_ANG_LO: begin
                o_cmd.op = sdwk_pkg::OP_ANG_LO;
                n_state  = sdwk_pkg::S_ANG_HI;
            end
            sdwk_pkg::S_ANG_HI: begin
                o_cmd.op = sdwk_pkg::OP_ANG_HI;
                n_state  = sdwk_pkg::S_SPD_INIT;
            end
            sdwk_pkg::S_SPD_INIT: begin
                o_cmd.op = sdwk_pkg::OP_SPD_INIT;
                n_step   = '0;
                n_state  = sdwk_pkg::S_SPD_STEP;
            end
            sdwk_pkg::S_SPD_STEP: begin
                o_cmd.op = sdwk_pkg::OP_VEC_STEP;
                n_step   = r_step + 1'b1;
                if (step_last) begin
                    n_step  = '0;
                    n_state = sdwk_pkg::S_MAG_LO;
                end
            end
            sdwk_pkg::S_MAG_LO: begin
                o_cmd.op = sdwk_pkg::OP_MAG_LO;
                n_state  = sdwk_pkg::S_MAG_HI;
            end
            sdwk_pkg::S_MAG_HI: begin
                o_cmd.op = sdwk_pkg::OP_MAG_HI;
                if (r_wheel == sdwk_pkg::WHEEL_W'(sdwk_pkg::NUM_WHEELS - 1)) begin
                    n_state = sdwk_pkg::S_DONE;
                end else begin
                    n_wheel = r_wheel + 1'b1;
                    n_state = sdwk_pkg::S_WVEC;
                end
            end
            sdwk_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.op    = sdwk_pkg::OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = sdwk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdwk_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/sdwk_dp.sv =====
// Datapath of the swerve kinematics block: shared CORDIC, multipliers and wheel state.
// Depends on sdwk_pkg; executes the commands issued by sdwk_ctrl.
`default_nettype none

module sdwk_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  sdwk_pkg::t_cmd              i_cmd,
    output sdwk_pkg::t_sts              o_sts,
    input  wire                         i_standby,
    input  wire signed [15:0]           i_vel_x,
    input  wire signed [15:0]           i_vel_y,
    input  wire signed [15:0]           i_omega,
    input  wire signed [15:0]           i_heading,
    input  wire signed [15:0]           i_arm_x,
    input  wire signed [15:0]           i_arm_y,
    output logic signed [31:0]          o_angle [sdwk_pkg::NUM_WHEELS],
    output logic signed [17:0]          o_speed [sdwk_pkg::NUM_WHEELS]
);

    localparam int CW = sdwk_pkg::CW;
    localparam int ZW = sdwk_pkg::ZW;

    logic                   r_standby;
    logic signed [15:0]     r_vx, r_vy, r_w, r_h;
    logic signed [CW-1:0]   r_x, r_y, r_acc;
    logic signed [ZW-1:0]   r_z;
    logic signed [17:0]     r_lx, r_ly, r_cx, r_cy;
    logic signed [19:0]     r_wa, r_wb;
    logic signed [35:0]     r_p1, r_p2;
    logic signed [36:0]     r_dot, r_cross;
    logic signed [41:0]     r_sq;
    logic                   r_big, r_gate;
    logic signed [17:0]     r_dir_x [sdwk_pkg::NUM_WHEELS];
    logic signed [17:0]     r_dir_y [sdwk_pkg::NUM_WHEELS];
    logic                   r_rev   [sdwk_pkg::NUM_WHEELS];
    logic signed [31:0]     r_ang   [sdwk_pkg::NUM_WHEELS];
    logic signed [17:0]     r_spd   [sdwk_pkg::NUM_WHEELS];
    logic signed [31:0]     r_o_angle [sdwk_pkg::NUM_WHEELS];
    logic signed [17:0]     r_o_speed [sdwk_pkg::NUM_WHEELS];

    logic [sdwk_pkg::WHEEL_W-1:0] k;
    logic signed [CW-1:0]   sh_x, sh_y, rnd_half;
    logic signed [ZW-1:0]   atan_v, h_ext, a0;
    logic signed [35:0]     g_lo_p, a_lo_p;
    logic signed [34:0]     g_hi_p, a_hi_p;
    logic signed [CW-1:0]   g_res, a_res;
    logic signed [31:0]     wa_p, wb_p;
    logic signed [32:0]     wa_r, wb_r;
    logic signed [19:0]     sa, sb;
    logic signed [20:0]     cx_sum, cy_sum;
    logic signed [18:0]     cx_ext, cx_abs;
    logic signed [36:0]     dot_abs, cross_adj;
    logic signed [41:0]     c_sq;
    logic signed [17:0]     mag;
    logic                   rev_now;

    function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
        logic signed [17:0] r;
        if (v > 21'(sdwk_pkg::SPD_MAX)) begin
            r = sdwk_pkg::SPD_MAX;
        end else if (v < 21'(sdwk_pkg::SPD_MIN)) begin
            r = sdwk_pkg::SPD_MIN;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    assign k        = i_cmd.wheel;
    assign sh_x     = r_x >>> i_cmd.step;
    assign sh_y     = r_y >>> i_cmd.step;
    assign atan_v   = sdwk_pkg::atan_entry(5'(i_cmd.step));
    assign rnd_half = CW'(1) <<< 31;

    assign h_ext = ZW'(r_h) <<< 16;
    assign a0    = -h_ext;

    assign g_lo_p = $signed({1'b0, r_x[17:0]}) * sdwk_pkg::INV_GAIN;
    assign g_hi_p = $signed(r_x[35:18]) * sdwk_pkg::INV_GAIN;
    assign g_res  = ((CW'(g_hi_p) <<< 18) + r_acc + rnd_half) >>> 32;

    assign a_lo_p = $signed({1'b0, r_z[16:0]}) * sdwk_pkg::DEG_PER_TURN;
    assign a_hi_p = $signed(r_z[33:17]) * sdwk_pkg::DEG_PER_TURN;
    assign a_res  = ((CW'(a_hi_p) <<< 17) + r_acc + rnd_half) >>> 32;

    assign wa_p = r_w * i_arm_x;
    assign wb_p = r_w * i_arm_y;
    assign wa_r = (33'(wa_p) + 33'sd2048) >>> 12;
    assign wb_r = (33'(wb_p) + 33'sd2048) >>> 12;

    assign sa     = k[0] ? r_wa : -r_wa;
    assign sb     = k[1] ? -r_wb : r_wb;
    assign cx_sum = 21'(r_lx) + 21'(sa);
    assign cy_sum = 21'(r_ly) + 21'(sb);

    assign cx_ext    = 19'(r_cx);
    assign cx_abs    = r_cx[17] ? -cx_ext : cx_ext;
    assign dot_abs   = r_dot[36] ? -r_dot : r_dot;
    assign cross_adj = r_dot[36] ? -r_cross : r_cross;
    assign c_sq      = $signed(r_cross[20:0]) * $signed(r_cross[20:0]);

    assign mag     = (g_res > CW'(sdwk_pkg::SPD_MAX)) ? sdwk_pkg::SPD_MAX :
                     (g_res[CW-1] ? 18'sd0 : g_res[17:0]);
    assign rev_now = r_rev[k];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sdwk_pkg::NUM_WHEELS; i++) begin
                r_dir_x[i] <= sdwk_pkg::DIR_ONE;
                r_dir_y[i] <= '0;
                r_rev[i]   <= 1'b0;
                r_ang[i]   <= '0;
            end
        end else begin
            case (i_cmd.op)
                sdwk_pkg::OP_CLEAR: begin
                    for (int i = 0; i < sdwk_pkg::NUM_WHEELS; i++) begin
                        r_dir_x[i] <= sdwk_pkg::DIR_ONE;
                        r_dir_y[i] <= '0;
                        r_rev[i]   <= 1'b0;
                        r_ang[i]   <= '0;
                    end
                end
                sdwk_pkg::OP_ANG_HI: begin
                    r_ang[k] <= r_ang[k] + a_res[31:0];
                end
                sdwk_pkg::OP_SPD_INIT: begin
                    r_rev[k] <= r_rev[k] ^ r_dot[36];
                end
                sdwk_pkg::OP_MAG_HI: begin
                    r_dir_x[k] <= r_cx;
                    r_dir_y[k] <= r_cy;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sdwk_pkg::OP_LOAD: begin
                r_standby <= i_standby;
                r_vx      <= i_vel_x;
                r_vy      <= i_vel_y;
                r_w       <= i_omega;
                r_h       <= i_heading;
            end
            sdwk_pkg::OP_CLEAR, sdwk_pkg::OP_HOLD: begin
                for (int i = 0; i < sdwk_pkg::NUM_WHEELS; i++) begin
                    r_spd[i] <= '0;
                end
            end
            sdwk_pkg::OP_ROT_INIT: begin
                if (a0 > (ZW'(1) <<< 30)) begin
                    r_z <= a0 - (ZW'(1) <<< 31);
                    r_x <= -(CW'(r_vx) <<< 16);
                    r_y <= -(CW'(r_vy) <<< 16);
                end else if (a0 < -(ZW'(1) <<< 30)) begin
                    r_z <= a0 + (ZW'(1) <<< 31);
                    r_x <= -(CW'(r_vx) <<< 16);
                    r_y <= -(CW'(r_vy) <<< 16);
                end else begin
                    r_z <= a0;
                    r_x <= CW'(r_vx) <<< 16;
                    r_y <= CW'(r_vy) <<< 16;
                end
            end
            sdwk_pkg::OP_ROT_STEP: begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - sh_y;
                    r_y <= r_y + sh_x;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + sh_y;
                    r_y <= r_y - sh_x;
                    r_z <= r_z + atan_v;
                end
            end
            sdwk_pkg::OP_VEC_STEP: begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + sh_y;
                    r_y <= r_y - sh_x;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - sh_y;
                    r_y <= r_y + sh_x;
                    r_z <= r_z - atan_v;
                end
            end
            sdwk_pkg::OP_GX_LO, sdwk_pkg::OP_MAG_LO: begin
                r_acc <= CW'(g_lo_p);
            end
            sdwk_pkg::OP_GX_HI: begin
                r_lx <= g_res[17:0];
                r_x  <= r_y;
            end
            sdwk_pkg::OP_GY_LO: begin
                r_acc <= CW'(g_lo_p);
            end
            sdwk_pkg::OP_GY_HI: begin
                r_ly <= g_res[17:0];
            end
            sdwk_pkg::OP_ARM: begin
                r_wa <= wa_r[19:0];
                r_wb <= wb_r[19:0];
            end
            sdwk_pkg::OP_WVEC: begin
                r_cx <= sat18(cx_sum);
                r_cy <= sat18(cy_sum);
            end
            sdwk_pkg::OP_DOT: begin
                r_p1 <= r_dir_x[k] * r_cx;
                r_p2 <= r_dir_y[k] * r_cy;
            end
            sdwk_pkg::OP_CROSS: begin
                r_dot <= 37'(r_p1) + 37'(r_p2);
                r_p1  <= r_dir_x[k] * r_cy;
                r_p2  <= r_dir_y[k] * r_cx;
            end
            sdwk_pkg::OP_DIFF: begin
                r_cross <= 37'(r_p1) - 37'(r_p2);
            end
            sdwk_pkg::OP_SQ: begin
                r_sq  <= $signed(r_dot[20:0]) * $signed(r_dot[20:0]);
                r_big <= (r_dot >= 37'sd1048576) || (r_dot <= -37'sd1048576) ||
                         (r_cross >= 37'sd1048576) || (r_cross <= -37'sd1048576);
            end
            sdwk_pkg::OP_GATE: begin
                r_gate <= r_big || ((43'(r_sq) + 43'(c_sq)) > sdwk_pkg::GATE_Q48);
            end
            sdwk_pkg::OP_ANG_INIT: begin
                r_x <= CW'(dot_abs) <<< 16;
                r_y <= CW'(cross_adj) <<< 16;
                r_z <= '0;
            end
            sdwk_pkg::OP_ANG_LO: begin
                r_acc <= CW'(a_lo_p);
            end
            sdwk_pkg::OP_SPD_INIT: begin
                r_x <= CW'(cx_abs) <<< 16;
                r_y <= CW'(r_cy) <<< 16;
                r_z <= '0;
            end
            sdwk_pkg::OP_MAG_HI: begin
                r_spd[k] <= rev_now ? -mag : mag;
            end
            sdwk_pkg::OP_PUBLISH: begin
                for (int i = 0; i < sdwk_pkg::NUM_WHEELS; i++) begin
                    r_o_angle[i] <= r_ang[i];
                    r_o_speed[i] <= r_spd[i];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.standby  = r_standby;
    assign o_sts.zero_cmd = (r_vx == 16'sd0) && (r_vy == 16'sd0) && (r_w == 16'sd0);
    assign o_sts.gate     = r_gate;
    assign o_angle        = r_o_angle;
    assign o_speed        = r_o_speed;

endmodule

`default_nettype wire

// ===== hw/rtl/sdwk_checker.sv =====
// Port-level checker for the swerve kinematics block, bound to the top level.
// Depends on swerve_drive_wheel_kinematics_assert.svh.
`default_nettype none

`include "swerve_drive_wheel_kinematics_assert.svh"

module sdwk_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_valid,
    input wire          o_ready,
    input wire          o_valid,
    input wire          i_ready,
    input wire [31:0]   o_angle_front_right,
    input wire [17:0]   o_speed_front_right,
    input wire          psel,
    input wire          penable,
    input wire          pwrite,
    input wire [2:0]    paddr,
    input wire [31:0]   pwdata,
    input wire [31:0]   prdata,
    input wire          pready
);

    // A result that is not taken must hold.
    `SDWK_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_angle_front_right) && $stable(o_speed_front_right), "result changed while stalled")

    // After a transaction is accepted the block is busy in the next cycle.
    `SDWK_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "input accepted back to back")

    // A write to the arm_x lever register reads back.
    `SDWK_ASSERT_RST(a_cfg_readback, i_clk, i_rst_n, (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |-> prdata[15:0] == $past(pwdata[15:0]), "arm_x readback mismatch")

    `SDWK_ASSERT_ALWAYS(a_pready, i_clk, pready, "pready dropped")

    // Reset leaves no result pending and the input side open.
    `SDWK_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_valid && o_ready, "bad state after reset")

endmodule

bind swerve_drive_wheel_kinematics sdwk_checker u_sdwk_checker (.*);

`default_nettype wire
